// ----- rtl/frs_pkg.sv -----
// Package for the flip recovery sequencer: phase and controller state types,
// output codes, register defaults, status structs and the power cap function.
// No dependencies; the elapsed, ramp and top-level modules and the bench import it.
`default_nettype none

package frs_pkg;

  localparam int TIME_W   = 32;
  localparam int DUR_W    = 16;
  localparam int POWER_W  = 7;
  localparam int HALF_W   = POWER_W - 1;
  localparam int RETRY_W  = 4;
  localparam int PROD_W   = DUR_W + HALF_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_START_POWER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_DUR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPIN_TMO    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VERIFY_WAIT = 2'd3;

  localparam logic [POWER_W-1:0] START_POWER_RST = 7'd50;
  localparam logic [DUR_W-1:0]   RAMP_DUR_RST    = 16'd1000;
  localparam logic [DUR_W-1:0]   SPIN_TMO_RST    = 16'd500;
  localparam logic [DUR_W-1:0]   VERIFY_WAIT_RST = 16'd2500;

  localparam logic [POWER_W-1:0] POWER_CAP   = 7'd100;
  localparam logic [RETRY_W-1:0] RETRY_LIMIT = 4'd3;

  localparam logic [1:0] SERVO_NONE    = 2'd0;
  localparam logic [1:0] SERVO_HOLD    = 2'd1;
  localparam logic [1:0] SERVO_RELEASE = 2'd2;

  localparam logic [1:0] OUTC_NONE    = 2'd0;
  localparam logic [1:0] OUTC_UPRIGHT = 2'd1;
  localparam logic [1:0] OUTC_FAILED  = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_CHECK  = 3'd1,
    PH_WAIT   = 3'd2,
    PH_SPIN   = 3'd3,
    PH_RAMP   = 3'd4,
    PH_VERIFY = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TIME,
    S_RAMP,
    S_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    R_IDLE,
    R_MUL,
    R_DIV
  } ramp_state_t;

  typedef struct packed {
    logic             done;
    logic             gt;
    logic [DUR_W-1:0] diff;
  } elapsed_stat_t;

  typedef struct packed {
    logic              done;
    logic [HALF_W-1:0] quot;
  } ramp_stat_t;

  typedef struct packed {
    logic               drive_valid;
    logic [POWER_W-1:0] drive_power;
    logic [1:0]         servo_cmd;
    logic               side_request;
    logic               running;
    logic [1:0]         outcome;
  } result_t;

  function automatic logic [POWER_W-1:0] cap_power(input logic [POWER_W:0] p);
    cap_power = (p > {1'b0, POWER_CAP}) ? POWER_CAP : p[POWER_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/frs_in_if.sv -----
// Input channel of the flip recovery sequencer: valid, ready and one tick's
// timestamp and sensor flags. No dependencies.
`default_nettype none

interface frs_in_if;
  logic        valid;
  logic        ready;
  logic        start_req;
  logic [31:0] now_ms;
  logic        lying_on_side;
  logic        upside_down;
  logic        side_recovery_busy;

  modport source (
    output valid, start_req, now_ms, lying_on_side, upside_down, side_recovery_busy,
    input  ready
  );

  modport sink (
    input  valid, start_req, now_ms, lying_on_side, upside_down, side_recovery_busy,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/frs_out_if.sv -----
// Result channel of the flip recovery sequencer: valid, ready and the drive,
// servo, side request and outcome fields of one result. No dependencies.
`default_nettype none

interface frs_out_if;
  logic       valid;
  logic       ready;
  logic       drive_valid;
  logic [6:0] drive_power;
  logic [1:0] servo_cmd;
  logic       side_request;
  logic       running;
  logic [1:0] outcome;

  modport source (
    output valid, drive_valid, drive_power, servo_cmd, side_request, running, outcome,
    input  ready
  );

  modport sink (
    input  valid, drive_valid, drive_power, servo_cmd, side_request, running, outcome,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/frs_elapsed.sv -----
// Bit-serial elapsed time unit: forms now - mark, compares it with a threshold
// and forms threshold - elapsed, one bit per cycle, LSB first. Uses frs_pkg.
`default_nettype none

module frs_elapsed (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [frs_pkg::TIME_W-1:0]  now,
  input  wire logic [frs_pkg::TIME_W-1:0]  mark,
  input  wire logic [frs_pkg::DUR_W-1:0]   thr,
  output frs_pkg::elapsed_stat_t           stat
);
  import frs_pkg::*;

  localparam int CNT_W = $clog2(TIME_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [TIME_W-1:0] a_r;
  logic [TIME_W-1:0] b_r;
  logic [DUR_W-1:0]  t_r;
  logic              bw1_r;
  logic              bw2_r;
  logic              gt_r;
  logic [DUR_W-1:0]  diff_r;

  logic dt_bit;
  logic diff_bit;
  logic bw1_nxt;
  logic bw2_nxt;
  logic gt_nxt;

  always_comb begin
    dt_bit   = a_r[0] ^ b_r[0] ^ bw1_r;
    bw1_nxt  = (~a_r[0] & b_r[0]) | (~a_r[0] & bw1_r) | (b_r[0] & bw1_r);
    gt_nxt   = (dt_bit != t_r[0]) ? dt_bit : gt_r;
    diff_bit = t_r[0] ^ dt_bit ^ bw2_r;
    bw2_nxt  = (~t_r[0] & dt_bit) | (~t_r[0] & bw2_r) | (dt_bit & bw2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(TIME_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= now;
      b_r   <= mark;
      t_r   <= thr;
      bw1_r <= 1'b0;
      bw2_r <= 1'b0;
      gt_r  <= 1'b0;
    end else if (busy_r) begin
      a_r   <= {1'b0, a_r[TIME_W-1:1]};
      b_r   <= {1'b0, b_r[TIME_W-1:1]};
      t_r   <= {1'b0, t_r[DUR_W-1:1]};
      bw1_r <= bw1_nxt;
      bw2_r <= bw2_nxt;
      gt_r  <= gt_nxt;
      if (cnt_r < CNT_W'(DUR_W)) begin
        diff_r <= {diff_bit, diff_r[DUR_W-1:1]};
      end
    end
  end

  assign stat.done = done_r;
  assign stat.gt   = gt_r;
  assign stat.diff = diff_r;

endmodule

`default_nettype wire

// ----- rtl/frs_ramp.sv -----
// Serial ramp power unit: (dur - dt) * half by shift-add, one multiplier bit per
// cycle, then division by dur, one quotient bit per cycle. Uses frs_pkg.
`default_nettype none

module frs_ramp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [frs_pkg::DUR_W-1:0]   diff,
  input  wire logic [frs_pkg::HALF_W-1:0]  half,
  input  wire logic [frs_pkg::DUR_W-1:0]   dur,
  output frs_pkg::ramp_stat_t              stat
);
  import frs_pkg::*;

  localparam int CNT_W = $clog2(HALF_W);

  ramp_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_nxt, done_r;
  logic [DUR_W-1:0]  mcand_r;
  logic [HALF_W-1:0] mplier_r;
  logic [PROD_W-1:0] acc_r;
  logic [DUR_W-1:0]  dur_r;
  logic [DUR_W-1:0]  rem_r;
  logic [HALF_W-1:0] lo_r;
  logic [HALF_W-1:0] quot_r;

  logic [PROD_W-1:0] acc_nxt;
  logic [DUR_W:0]    trial;
  logic [DUR_W:0]    trial_sub;
  logic              qbit;
  logic              last;

  always_comb begin
    acc_nxt   = {acc_r[PROD_W-2:0], 1'b0}
              + (mplier_r[HALF_W-1] ? {{HALF_W{1'b0}}, mcand_r} : {PROD_W{1'b0}});
    trial     = {rem_r, lo_r[HALF_W-1]};
    trial_sub = trial - {1'b0, dur_r};
    qbit      = (trial >= {1'b0, dur_r});
    last      = (cnt_r == CNT_W'(HALF_W - 1));
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      R_IDLE: begin
        if (start) begin
          state_nxt = R_MUL;
          cnt_nxt   = '0;
        end
      end
      R_MUL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last) begin
          state_nxt = R_DIV;
          cnt_nxt   = '0;
        end
      end
      R_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last) begin
          state_nxt = R_IDLE;
          done_nxt  = 1'b1;
        end
      end
      default: state_nxt = R_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == R_IDLE && start) begin
      mcand_r  <= diff;
      mplier_r <= half;
      dur_r    <= dur;
      acc_r    <= '0;
    end else if (state_r == R_MUL) begin
      acc_r    <= acc_nxt;
      mplier_r <= {mplier_r[HALF_W-2:0], 1'b0};
      if (last) begin
        rem_r  <= acc_nxt[PROD_W-1:HALF_W];
        lo_r   <= acc_nxt[HALF_W-1:0];
        quot_r <= '0;
      end
    end else if (state_r == R_DIV) begin
      rem_r  <= qbit ? trial_sub[DUR_W-1:0] : trial[DUR_W-1:0];
      lo_r   <= {lo_r[HALF_W-2:0], 1'b0};
      quot_r <= {quot_r[HALF_W-2:0], qbit};
    end
  end

  assign stat.done = done_r;
  assign stat.quot = quot_r;

endmodule

`default_nettype wire

// ----- rtl/flip_recovery_sequencer_top.sv -----
// Top level of the flip recovery sequencer: configuration registers, tick
// sequencer, phase state and result register. Uses frs_pkg, frs_in_if,
// frs_out_if, frs_elapsed and frs_ramp.
// An input transfer is followed by the bit-serial elapsed time pass and, when the
// ramp power is computed, the serial multiply and divide before the result is
// registered. A new tick is taken only once the result of the last one has been
// loaded into the output register; the next tick is taken while a result waits
// in the output register.
// Reset (synchronous, active low) restores the register defaults and idles.
`default_nettype none

module flip_recovery_sequencer_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  frs_in_if.sink                             in_chan,
  frs_out_if.source                          out_chan,
  input  wire logic                          cfg_we,
  input  wire logic [frs_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [frs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import frs_pkg::*;

  logic [POWER_W-1:0] start_power_r;
  logic [DUR_W-1:0]   ramp_dur_r;
  logic [DUR_W-1:0]   spin_tmo_r;
  logic [DUR_W-1:0]   verify_wait_r;

  seq_state_t         state_r, state_nxt;
  phase_t             phase_r, phase_nxt;
  logic [TIME_W-1:0]  mark_r, mark_nxt;
  logic [RETRY_W-1:0] retry_r, retry_nxt;

  logic               start_r;
  logic [TIME_W-1:0]  now_r;
  logic               side_r;
  logic               upside_r;
  logic               sbusy_r;

  logic               out_valid_r;
  result_t            out_r;
  result_t            res;

  elapsed_stat_t      el;
  ramp_stat_t         rp;

  logic               in_xfer;
  logic               el_start;
  logic               ramp_start;
  logic               need_ramp;
  logic               out_free;
  logic               out_load;
  logic [DUR_W-1:0]   thr;
  logic [HALF_W-1:0]  half;
  logic [RETRY_W:0]   retry_inc;
  logic [POWER_W:0]   retry_power;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_power_r <= START_POWER_RST;
      ramp_dur_r    <= RAMP_DUR_RST;
      spin_tmo_r    <= SPIN_TMO_RST;
      verify_wait_r <= VERIFY_WAIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_START_POWER: start_power_r <= cfg_wdata[POWER_W-1:0];
        CFG_RAMP_DUR:    ramp_dur_r    <= cfg_wdata[DUR_W-1:0];
        CFG_SPIN_TMO:    spin_tmo_r    <= cfg_wdata[DUR_W-1:0];
        CFG_VERIFY_WAIT: verify_wait_r <= cfg_wdata[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign el_start      = in_xfer;
  assign half          = start_power_r[POWER_W-1:1];
  assign out_free      = !out_valid_r || out_chan.ready;

  always_comb begin
    case (phase_r)
      PH_SPIN:   thr = spin_tmo_r;
      PH_RAMP:   thr = ramp_dur_r;
      PH_VERIFY: thr = verify_wait_r;
      default:   thr = '0;
    endcase
  end

  assign need_ramp = !start_r && (phase_r == PH_RAMP) && !el.gt && (ramp_dur_r != '0);

  always_comb begin
    state_nxt  = state_r;
    ramp_start = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) state_nxt = S_TIME;
      end
      S_TIME: begin
        if (el.done) begin
          if (need_ramp) begin
            ramp_start = 1'b1;
            state_nxt  = S_RAMP;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_RAMP: begin
        if (rp.done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    retry_inc   = {1'b0, retry_r} + 1'b1;
    retry_power = {1'b0, start_power_r}
                + {1'b0, retry_inc, 2'b00} + {3'b000, retry_inc};
  end

  always_comb begin
    res       = '0;
    phase_nxt = phase_r;
    mark_nxt  = mark_r;
    retry_nxt = retry_r;
    if (start_r) begin
      phase_nxt = PH_CHECK;
      retry_nxt = '0;
      mark_nxt  = now_r;
    end else begin
      case (phase_r)
        PH_CHECK, PH_WAIT: begin
          if (phase_r == PH_CHECK && side_r) begin
            res.side_request = 1'b1;
            phase_nxt        = PH_WAIT;
          end else begin
            if (phase_r == PH_CHECK) res.servo_cmd = SERVO_HOLD;
            if (!sbusy_r) begin
              res.drive_valid = 1'b1;
              res.drive_power = cap_power({1'b0, start_power_r});
              mark_nxt        = now_r;
              phase_nxt       = PH_SPIN;
            end
          end
        end
        PH_SPIN: begin
          if (el.gt) begin
            mark_nxt        = now_r;
            phase_nxt       = PH_VERIFY;
            res.drive_valid = 1'b1;
          end
          if (upside_r) begin
            mark_nxt  = now_r;
            phase_nxt = PH_RAMP;
          end
        end
        PH_RAMP: begin
          res.drive_valid = 1'b1;
          if (el.gt) begin
            mark_nxt  = now_r;
            phase_nxt = PH_VERIFY;
          end else if (ramp_dur_r == '0) begin
            res.drive_power = {1'b0, half};
          end else begin
            res.drive_power = {1'b0, rp.quot};
          end
        end
        PH_VERIFY: begin
          if (el.gt) begin
            res.drive_valid = 1'b1;
            if (!upside_r) begin
              res.servo_cmd = SERVO_RELEASE;
              res.outcome   = OUTC_UPRIGHT;
              phase_nxt     = PH_IDLE;
            end else begin
              mark_nxt  = now_r;
              retry_nxt = retry_inc[RETRY_W-1:0];
              if (retry_inc[RETRY_W-1:0] > RETRY_LIMIT) begin
                res.outcome = OUTC_FAILED;
                phase_nxt   = PH_IDLE;
              end else begin
                res.drive_power = cap_power(retry_power);
                res.servo_cmd   = SERVO_HOLD;
              end
            end
          end
        end
        default: ;
      endcase
    end
    res.running = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_IDLE;
      mark_r      <= '0;
      retry_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        phase_r     <= phase_nxt;
        mark_r      <= mark_nxt;
        retry_r     <= retry_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      start_r  <= in_chan.start_req;
      now_r    <= in_chan.now_ms;
      side_r   <= in_chan.lying_on_side;
      upside_r <= in_chan.upside_down;
      sbusy_r  <= in_chan.side_recovery_busy;
    end
    if (out_load) out_r <= res;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.drive_valid  = out_r.drive_valid;
  assign out_chan.drive_power  = out_r.drive_power;
  assign out_chan.servo_cmd    = out_r.servo_cmd;
  assign out_chan.side_request = out_r.side_request;
  assign out_chan.running      = out_r.running;
  assign out_chan.outcome      = out_r.outcome;

  frs_elapsed u_elapsed (
    .clk   (clk),
    .rst_n (rst_n),
    .start (el_start),
    .now   (in_chan.now_ms),
    .mark  (mark_r),
    .thr   (thr),
    .stat  (el)
  );

  frs_ramp u_ramp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ramp_start),
    .diff  (el.diff),
    .half  (half),
    .dur   (ramp_dur_r),
    .stat  (rp)
  );

  a_ramp_done_in_ramp: assert property (@(posedge clk) disable iff (!rst_n)
    rp.done |-> state_r == S_RAMP)
    else $error("ramp unit finished outside the ramp wait");

  a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rp.done |-> rp.quot <= half)
    else $error("ramp power exceeds half the start power");

  a_el_done_in_time: assert property (@(posedge clk) disable iff (!rst_n)
    el.done |-> state_r == S_TIME)
    else $error("elapsed time pass finished outside its wait");

  a_outcome_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && res.outcome != OUTC_NONE |-> !res.running && res.drive_power == '0)
    else $error("finished sequence still running or driving");

  a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result register overwritten before its transfer");

endmodule

`default_nettype wire

// ----- bench/frs_check_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard for the flip recovery sequencer bench: the tick type, an in-order
// prediction of the result of each tick and the field-by-field result check.
// Depends on frs_pkg.
package frs_check_pkg;
  import frs_pkg::*;

  localparam logic [POWER_W:0] RETRY_STEP = 8'd5;

  typedef struct packed {
    logic              start_req;
    logic [TIME_W-1:0] now_ms;
    logic              lying_on_side;
    logic              upside_down;
    logic              side_recovery_busy;
  } tick_t;

  class righting_scoreboard;
    logic [POWER_W-1:0] start_power;
    logic [DUR_W-1:0]   ramp_ms;
    logic [DUR_W-1:0]   spin_ms;
    logic [DUR_W-1:0]   verify_ms;
    phase_t             phase;
    logic [TIME_W-1:0]  mark_ms;
    logic [RETRY_W-1:0] retries;
    result_t            awaited_results[$];
    int                 errors;

    function new();
      start_power = START_POWER_RST;
      ramp_ms = RAMP_DUR_RST;
      spin_ms = SPIN_TMO_RST;
      verify_ms = VERIFY_WAIT_RST;
      phase = PH_IDLE;
      mark_ms = '0;
      retries = '0;
      errors = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_START_POWER: start_power = data[POWER_W-1:0];
        CFG_RAMP_DUR: ramp_ms = data;
        CFG_SPIN_TMO: spin_ms = data;
        CFG_VERIFY_WAIT: verify_ms = data;
        default: ;
      endcase
    endfunction

    function logic [POWER_W-1:0] limit_pct(logic [POWER_W:0] pct);
      return (pct > {1'b0, POWER_CAP}) ? POWER_CAP : pct[POWER_W-1:0];
    endfunction

    function void note_tick(tick_t t);
      result_t           res;
      logic [TIME_W-1:0] elapsed;
      logic [TIME_W-1:0] scaled;
      logic [HALF_W-1:0] half;
      res = '0;
      elapsed = t.now_ms - mark_ms;
      half = start_power[POWER_W-1:1];
      if (t.start_req) begin
        phase = PH_CHECK;
        retries = '0;
        mark_ms = t.now_ms;
      end else if (phase == PH_CHECK && t.lying_on_side) begin
        res.side_request = 1'b1;
        phase = PH_WAIT;
      end else if (phase == PH_CHECK || phase == PH_WAIT) begin
        if (phase == PH_CHECK) res.servo_cmd = SERVO_HOLD;
        if (!t.side_recovery_busy) begin
          res.drive_valid = 1'b1;
          res.drive_power = limit_pct({1'b0, start_power});
          mark_ms = t.now_ms;
          phase = PH_SPIN;
        end
      end else if (phase == PH_SPIN) begin
        if (elapsed > TIME_W'(spin_ms)) begin
          res.drive_valid = 1'b1;
          mark_ms = t.now_ms;
          phase = PH_VERIFY;
        end
        if (t.upside_down) begin
          mark_ms = t.now_ms;
          phase = PH_RAMP;
        end
      end else if (phase == PH_RAMP) begin
        res.drive_valid = 1'b1;
        if (elapsed > TIME_W'(ramp_ms)) begin
          mark_ms = t.now_ms;
          phase = PH_VERIFY;
        end else if (ramp_ms == '0) begin
          res.drive_power = POWER_W'(half);
        end else begin
          scaled = (TIME_W'(ramp_ms) - elapsed) * TIME_W'(half);
          res.drive_power = POWER_W'(scaled / TIME_W'(ramp_ms));
        end
      end else if (phase == PH_VERIFY && elapsed > TIME_W'(verify_ms)) begin
        res.drive_valid = 1'b1;
        if (!t.upside_down) begin
          res.servo_cmd = SERVO_RELEASE;
          res.outcome = OUTC_UPRIGHT;
          phase = PH_IDLE;
        end else begin
          mark_ms = t.now_ms;
          retries = retries + 1'b1;
          if (retries > RETRY_LIMIT) begin
            res.outcome = OUTC_FAILED;
            phase = PH_IDLE;
          end else begin
            res.servo_cmd = SERVO_HOLD;
            res.drive_power = limit_pct({1'b0, start_power} + 8'(retries) * RETRY_STEP);
          end
        end
      end
      res.running = (phase != PH_IDLE);
      awaited_results.push_back(res);
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: result transfer with nothing expected, expected none, actual %h",
                 $time, got);
        return;
      end
      want = awaited_results.pop_front();
      report("drive_valid", want.drive_valid, got.drive_valid);
      report("drive_power", want.drive_power, got.drive_power);
      report("servo_cmd", want.servo_cmd, got.servo_cmd);
      report("side_request", want.side_request, got.side_request);
      report("running", want.running, got.running);
      report("outcome", want.outcome, got.outcome);
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction
  endclass

endpackage

// ----- bench/flip_recovery_sequencer_top_test.sv -----
`timescale 1ns / 100ps
// Top-level bench for flip_recovery_sequencer_top: drives ticks and register
// writes, stalls both channels at random and checks every result in order.
// Depends on frs_pkg, frs_in_if, frs_out_if and frs_check_pkg.
module flip_recovery_sequencer_top_test;
  import frs_pkg::*;
  import frs_check_pkg::*;

  localparam int RANDOM_TICKS   = 550;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 60;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  frs_in_if  in_if ();
  frs_out_if out_if ();

  righting_scoreboard tracker;
  logic [TIME_W-1:0]  clock_ms;
  int                 max_step = 500;
  bit                 calm = 1'b0;
  bit                 sink_level = 1'b0;
  int                 sink_run = 0;
  int                 stall_cycles = 0;

  flip_recovery_sequencer_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm) return 0;
    if (roll < 70) return $urandom_range(0, 2);
    if (roll < 95) return $urandom_range(3, 12);
    return $urandom_range(20, 200);
  endfunction

  function automatic logic [DUR_W-1:0] pick_duration();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return DUR_W'($urandom_range(0, 60));
      3: return DUR_W'($urandom_range(0, 3000));
      default: return DUR_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_tick(input bit start, input logic [TIME_W-1:0] now, input bit side,
                           input bit up, input bit busy);
    tick_t t;
    int    gap;
    t = {start, now, side, up, busy};
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.start_req <= t.start_req;
    in_if.now_ms <= t.now_ms;
    in_if.lying_on_side <= t.lying_on_side;
    in_if.upside_down <= t.upside_down;
    in_if.side_recovery_busy <= t.side_recovery_busy;
    do @(negedge clk); while (!in_if.ready);
    @(posedge clk);
    tracker.note_tick(t);
  endtask

  task automatic send_random_tick();
    logic [TIME_W-1:0] now;
    bit                side;
    bit                up;
    if ($urandom_range(0, 49) == 0) clock_ms = clock_ms + $urandom();
    else clock_ms = clock_ms + $urandom_range(0, max_step);
    now = ($urandom_range(0, 39) == 0) ? $urandom() : clock_ms;
    side = ($urandom_range(0, (tracker.phase == PH_CHECK) ? 3 : 7) == 0);
    if (tracker.phase == PH_SPIN) up = ($urandom_range(0, 4) == 0);
    else if (tracker.phase == PH_VERIFY) up = ($urandom_range(0, 2) != 0);
    else up = 1'($urandom_range(0, 1));
    send_tick($urandom_range(0, 39) == 0, now, side, up, $urandom_range(0, 2) == 0);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    tracker.set_register(idx, data);
  endtask

  task automatic load_config(input logic [CFG_DATA_W-1:0] power, input logic [DUR_W-1:0] ramp,
                             input logic [DUR_W-1:0] spin, input logic [DUR_W-1:0] verify);
    write_reg(CFG_START_POWER, power);
    write_reg(CFG_RAMP_DUR, ramp);
    write_reg(CFG_SPIN_TMO, spin);
    write_reg(CFG_VERIFY_WAIT, verify);
    cfg_we <= 1'b0;
  endtask

  task automatic pick_config();
    logic [CFG_DATA_W-1:0] power;
    logic [DUR_W-1:0]      ramp;
    logic [DUR_W-1:0]      spin;
    logic [DUR_W-1:0]      verify;
    int                    longest;
    case ($urandom_range(0, 4))
      0: power = '0;
      1: power = CFG_DATA_W'(POWER_CAP);
      2: power = CFG_DATA_W'(127);
      3: power = CFG_DATA_W'($urandom_range(0, 100));
      default: power = CFG_DATA_W'($urandom_range(0, 65535));
    endcase
    ramp = pick_duration();
    spin = pick_duration();
    verify = pick_duration();
    longest = int'(ramp);
    if (int'(spin) > longest) longest = int'(spin);
    if (int'(verify) > longest) longest = int'(verify);
    max_step = longest / 5 + 2;
    load_config(power, ramp, spin, verify);
  endtask

  always @(posedge clk) begin
    if (sink_run == 0) begin
      sink_level = calm || !sink_level;
      sink_run = sink_level ? $urandom_range(1, 30) : pick_gap() + 1;
    end
    sink_run = sink_run - 1;
    out_if.ready <= sink_level;
  end

  always @(negedge clk) begin
    if (out_if.valid && out_if.ready)
      tracker.check_result({out_if.drive_valid, out_if.drive_power, out_if.servo_cmd,
                            out_if.side_request, out_if.running, out_if.outcome});
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) stall_cycles = 0;
    else stall_cycles = stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [TIME_W-1:0] mark;
    int                counted;
    int                run_len;
    int                n;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.start_req = 1'b0;
    in_if.now_ms = '0;
    in_if.lying_on_side = 1'b0;
    in_if.upside_down = 1'b0;
    in_if.side_recovery_busy = 1'b0;
    out_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_START_POWER;
    cfg_wdata = '0;
    clock_ms = $urandom();
    tracker = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Default registers, starting just below the 32-bit time wrap.
    mark = 32'hFFFF_FF00;
    send_tick(0, 32'h0, 0, 0, 0);
    send_tick(1, mark, 1, 1, 1);
    send_tick(0, mark + 1, 1, 0, 0);
    send_tick(0, mark + 2, 1, 0, 1);
    mark = mark + 3;
    send_tick(0, mark, 0, 0, 0);
    // The spin timeout and the rotation arrive in the same tick.
    mark = mark + 501;
    send_tick(0, mark, 0, 1, 0);
    send_tick(0, mark, 0, 0, 0);
    send_tick(0, mark + 500, 0, 0, 0);
    send_tick(0, mark + 1000, 0, 0, 0);
    mark = mark + 1001;
    send_tick(0, mark, 0, 0, 0);
    send_tick(0, mark + 2500, 0, 1, 0);
    repeat (4) begin
      mark = mark + 2501;
      send_tick(0, mark, 0, 1, 0);
    end
    send_tick(0, 32'hFFFF_FFFF, 1, 1, 1);

    // Start power above the cap, zero ramp, zero timeouts.
    drain();
    load_config(16'hFF7F, '0, '0, '0);
    mark = 32'h1234_5678;
    send_tick(1, mark, 0, 0, 0);
    send_tick(0, mark, 0, 0, 1);
    mark = mark + 1;
    send_tick(0, mark, 0, 0, 0);
    send_tick(0, mark, 0, 1, 0);
    send_tick(0, mark, 0, 0, 0);
    send_tick(0, mark + 1, 0, 0, 0);
    send_tick(0, mark + 2, 0, 0, 0);
    send_tick(1, mark + 3, 0, 0, 0);
    send_tick(1, mark + 4, 1, 0, 0);

    drain();
    pick_config();
    counted = 0;
    while (counted < RANDOM_TICKS) begin
      if ($urandom_range(0, 2) == 0) begin
        drain();
        pick_config();
      end
      calm = ($urandom_range(0, 5) == 0);
      clock_ms = clock_ms + $urandom_range(0, max_step);
      send_tick(1, clock_ms, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
      counted++;
      run_len = $urandom_range(8, 90);
      for (n = 0; n < run_len && tracker.phase != PH_IDLE; n++) begin
        send_random_tick();
        counted++;
      end
      repeat ($urandom_range(0, 2)) begin
        send_tick(0, $urandom(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
        counted++;
      end
    end

    drain();
    calm = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
